// ----- hdl/tid_pkg.sv -----
// shared constants of the time integrating debouncer
package tid_pkg;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [1:0] REG_DEBOUNCE_DELAY = 2'd0;
    localparam logic [1:0] REG_REPEAT_DELAY   = 2'd1;
    localparam logic [1:0] REG_REPEAT_ENABLE  = 2'd2;

    localparam logic [15:0] DEBOUNCE_DELAY_RESET = 16'd50;
    localparam logic [15:0] REPEAT_DELAY_RESET   = 16'd1000;
    localparam logic        REPEAT_ENABLE_RESET  = 1'b1;

endpackage

// ----- hdl/time_integrating_debouncer.sv -----
// time integrating debouncer with edge detect and hold repeat counter
// Samples pass through an input register and then a result register, where each sample's
// result is held until taken. The block takes one sample every cycle while the
// result side is not stalled, because the integrator and repeat state are updated in a
// single pass between those two registers. Either register drains as soon as the result is
// taken, so a stall on the result side backs up at most two samples. Timestamps and elapsed
// times are modular over TIME_BITS bits. The three settings sit at byte addresses 0, 4 and 8
// of the APB port and should be changed only while no sample is in flight.
module time_integrating_debouncer
    import tid_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_raw_level,
    input  logic [31:0]              s_sample_time_ms,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_stable_level,
    output logic                     m_edge_seen,
    output logic                     m_rise_seen,
    output logic                     m_fall_seen,
    output logic [31:0]              m_hold_repeats
);

    logic [15:0]          debounce_delay_reg;
    logic [15:0]          repeat_delay_reg;
    logic                 repeat_enable_reg;

    logic                 in_valid_reg;
    logic                 in_level_reg;
    logic [31:0]          in_time_reg;

    logic [TIME_BITS-1:0] last_time_reg;
    logic [15:0]          sum_reg;
    logic                 level_reg;
    logic [31:0]          repeat_total_reg;
    logic [TIME_BITS-1:0] last_repeat_reg;

    logic [TIME_BITS-1:0] last_time_next;
    logic [15:0]          sum_next;
    logic                 level_next;
    logic [31:0]          repeat_total_next;
    logic [TIME_BITS-1:0] last_repeat_next;
    logic                 edge_next;
    logic                 rise_next;
    logic                 fall_next;
    logic [31:0]          hold_next;

    logic                 out_valid_reg;
    logic                 out_level_reg;
    logic                 out_edge_reg;
    logic                 out_rise_reg;
    logic                 out_fall_reg;
    logic [31:0]          out_hold_reg;

    logic                 cfg_write;
    logic                 advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_delay_reg <= DEBOUNCE_DELAY_RESET;
            repeat_delay_reg   <= REPEAT_DELAY_RESET;
            repeat_enable_reg  <= REPEAT_ENABLE_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_DEBOUNCE_DELAY: debounce_delay_reg <= pwdata[15:0];
                REG_REPEAT_DELAY:   repeat_delay_reg   <= pwdata[15:0];
                REG_REPEAT_ENABLE:  repeat_enable_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DEBOUNCE_DELAY: prdata = {16'd0, debounce_delay_reg};
            REG_REPEAT_DELAY:   prdata = {16'd0, repeat_delay_reg};
            REG_REPEAT_ENABLE:  prdata = {31'd0, repeat_enable_reg};
            default:            prdata = '0;
        endcase
    end

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_level_reg <= s_raw_level;
            in_time_reg  <= s_sample_time_ms;
        end
    end

    // integrator and repeat update
    always_comb begin
        logic [TIME_BITS+31:0] now_wide;
        logic [TIME_BITS+15:0] sum_wide;
        logic [TIME_BITS+15:0] rep_wide;
        logic [TIME_BITS+15:0] gap_wide;
        logic [TIME_BITS-1:0]  now;
        logic [TIME_BITS-1:0]  delta;
        logic [TIME_BITS-1:0]  since_repeat;
        logic [15:0]           gap;

        now_wide     = {{TIME_BITS{1'b0}}, in_time_reg};
        now          = now_wide[TIME_BITS-1:0];
        delta        = now - last_time_reg;
        since_repeat = now - last_repeat_reg;
        gap          = debounce_delay_reg - sum_reg;
        sum_wide     = {{TIME_BITS{1'b0}}, sum_reg};
        rep_wide     = {{TIME_BITS{1'b0}}, repeat_delay_reg};
        gap_wide     = {{TIME_BITS{1'b0}}, gap};

        last_time_next    = now;
        sum_next          = sum_reg;
        level_next        = level_reg;
        repeat_total_next = repeat_total_reg;
        last_repeat_next  = last_repeat_reg;
        edge_next         = 1'b0;
        rise_next         = 1'b0;
        fall_next         = 1'b0;

        if (in_level_reg == level_reg) begin
            if (repeat_enable_reg) begin
                if (since_repeat >= rep_wide[TIME_BITS-1:0]) begin
                    repeat_total_next = repeat_total_reg + 32'd1;
                    last_repeat_next  = last_repeat_reg + rep_wide[TIME_BITS-1:0];
                end
            end else begin
                repeat_total_next = '0;
            end
            if (sum_wide[TIME_BITS-1:0] > delta) begin
                sum_next = sum_reg - delta[15:0];
            end else begin
                sum_next = '0;
            end
        end else if (debounce_delay_reg > sum_reg && delta < gap_wide[TIME_BITS-1:0]) begin
            sum_next = sum_reg + delta[15:0];
            if (!repeat_enable_reg) begin
                repeat_total_next = '0;
            end
        end else begin
            repeat_total_next = '0;
            last_repeat_next  = now;
            sum_next          = '0;
            rise_next         = in_level_reg && !level_reg;
            fall_next         = !in_level_reg && level_reg;
            edge_next         = 1'b1;
            level_next        = in_level_reg;
        end

        hold_next = repeat_enable_reg ? repeat_total_next : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg    <= '0;
            sum_reg          <= '0;
            level_reg        <= 1'b0;
            repeat_total_reg <= '0;
            last_repeat_reg  <= '0;
        end else if (advance) begin
            last_time_reg    <= last_time_next;
            sum_reg          <= sum_next;
            level_reg        <= level_next;
            repeat_total_reg <= repeat_total_next;
            last_repeat_reg  <= last_repeat_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_level_reg <= level_next;
            out_edge_reg  <= edge_next;
            out_rise_reg  <= rise_next;
            out_fall_reg  <= fall_next;
            out_hold_reg  <= hold_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_stable_level = out_level_reg;
    assign m_edge_seen    = out_edge_reg;
    assign m_rise_seen    = out_rise_reg;
    assign m_fall_seen    = out_fall_reg;
    assign m_hold_repeats = out_hold_reg;

    // checks
    a_edge_is_rise_or_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_edge_seen == (m_rise_seen || m_fall_seen)) && !(m_rise_seen && m_fall_seen))
        else $error("edge flag disagrees with rise and fall flags");

    a_rise_ends_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rise_seen |-> m_stable_level && level_reg == m_stable_level || in_valid_reg)
        else $error("rise reported without a high level");

    a_hold_zero_when_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !repeat_enable_reg |-> m_hold_repeats == 32'd0)
        else $error("repeat count shown while repeat is disabled");

    a_result_kept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hold_repeats) && $stable(m_stable_level))
        else $error("pending result lost under stall");

endmodule
